@@ hw/rtl/idfp_pkg.sv @@
// Shared types and constants for the inverse-distance fitness predictor.
// No dependencies; imported by every module of the block.
package idfp_pkg;

    localparam int PRM_W = 24;
    localparam int ERR_W = 24;
    localparam int SLOT_W = 6;
    localparam int CNT_CFG_W = 7;

    // (655360000)^2 and 1000000 in Q20.16
    localparam int NUM_W = 59;
    localparam logic [NUM_W-1:0] SIM_NUM_SQ = 59'd429496729600000000;
    localparam int SIM_W = 36;
    localparam logic [SIM_W-1:0] SIM_EXACT = 36'd65536000000;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [SLOT_W-1:0]          slot;
        logic [3:0][PRM_W-1:0]      prm;
        logic [ERR_W-1:0]           err;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

endpackage

@@ hw/rtl/idfp_front.sv @@
// Front end: takes command beats, drops loads aimed past capacity, and
// buffers the rest in a two-entry queue. Depends on idfp_pkg.
module idfp_front
    import idfp_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       item_in,
    input  logic        pop,
    output item_t       item_out,
    output queue_stat_t stat
);

    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        keep;
    logic        do_push;
    logic        do_pop;

    // a load outside the store is dropped here and never reaches the back end
    assign keep = (item_in.mode == MODE_QUERY) ||
                  (32'(item_in.slot) < 32'(MAX_MEMBERS));
    assign do_push = push && keep && (cnt_reg != 2'd2);
    assign do_pop  = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= item_in;
    end

    assign item_out   = q_mem[rd_ptr_reg];
    assign stat.valid = (cnt_reg != 2'd0);
    assign stat.full  = (cnt_reg == 2'd2);

endmodule

@@ hw/rtl/idfp_back.sv @@
// Back end: member stores, per-member distance, divide and square root,
// weighted sums and the final divide. Depends on idfp_pkg.
module idfp_back
    import idfp_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                item,
    input  queue_stat_t          stat,
    input  logic [CNT_CFG_W-1:0] member_count,
    output logic                 pop,
    output logic                 done,
    output logic [ERR_W-1:0]     estimate,
    output logic                 idle
);

    localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int TOT_W = SIM_W + CNT_W;
    localparam int ACC_W = SIM_W + ERR_W + CNT_W;
    localparam int D_W   = PRM_W + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int S_W   = SQ_W + 2;
    localparam int R_W   = NUM_W + 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_SQ   = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_FDIV = 4'd10;

    logic [3:0][PRM_W-1:0] prm_mem [MAX_MEMBERS];
    logic [ERR_W-1:0]      err_mem [MAX_MEMBERS];
    logic [3:0][PRM_W-1:0] prm_rd;
    logic [ERR_W-1:0]      err_rd;

    logic [3:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [3:0][PRM_W-1:0] cand_reg, cand_next;
    logic [3:0][D_W-1:0]   ad_reg, ad_next;
    logic [3:0][SQ_W-1:0]  sq_reg, sq_next;
    logic [S_W-1:0]        s_reg, s_next;
    logic [S_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [R_W-1:0]        x_reg, x_next;
    logic [R_W-1:0]        res_reg, res_next;
    logic [R_W-1:0]        bit_reg, bit_next;
    logic [SIM_W-1:0]      sim_reg, sim_next;
    logic [SIM_W+ERR_W-1:0] prod_reg, prod_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [TOT_W-1:0]      frem_reg, frem_next;
    logic [ERR_W-1:0]      fq_reg, fq_next;
    logic [5:0]            step_reg, step_next;
    logic [ERR_W-1:0]      est_reg, est_next;

    logic                  take;
    logic                  wr_load;
    logic [IDX_W-1:0]      wr_addr;
    logic [S_W:0]          div_try;
    logic [R_W-1:0]        sq_try;
    logic [TOT_W:0]        fdiv_try;
    logic [CNT_W-1:0]      n_sat;
    logic signed [D_W-1:0] diff [4];

    assign take    = (state_reg == ST_IDLE) && stat.valid;
    assign wr_load = take && (item.mode == MODE_LOAD);
    assign wr_addr = IDX_W'(item.slot);
    assign pop     = take;

    // member stores, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (wr_load)
        begin
            prm_mem[wr_addr] <= item.prm;
            err_mem[wr_addr] <= item.err;
        end
    end

    always_ff @(posedge clk)
    begin
        prm_rd <= prm_mem[idx_reg[IDX_W-1:0]];
        err_rd <= err_mem[idx_reg[IDX_W-1:0]];
    end

    assign n_sat = (32'(member_count) > 32'(MAX_MEMBERS)) ?
                   CNT_W'(MAX_MEMBERS) : CNT_W'(member_count);

    assign div_try  = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, s_reg};
    assign sq_try   = res_reg + bit_reg;
    assign fdiv_try = {frem_reg, fq_reg[ERR_W-1]} - {1'b0, total_reg};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            diff[k] = $signed({cand_reg[k][PRM_W-1], cand_reg[k]}) -
                      $signed({prm_rd[k][PRM_W-1], prm_rd[k]});
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        n_next     = n_reg;
        cand_next  = cand_reg;
        ad_next    = ad_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        sim_next   = sim_reg;
        prod_next  = prod_reg;
        total_next = total_reg;
        acc_next   = acc_reg;
        frem_next  = frem_reg;
        fq_next    = fq_reg;
        step_next  = step_reg;
        est_next   = est_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && item.mode == MODE_QUERY)
                begin
                    cand_next  = item.prm;
                    n_next     = n_sat;
                    idx_next   = '0;
                    total_next = '0;
                    acc_next   = '0;
                    state_next = (n_sat == '0) ? ST_FIN : ST_RD;
                end
            end
            ST_RD:
                state_next = ST_DIFF;
            ST_DIFF:
            begin
                for (int k = 0; k < 4; k++)
                    ad_next[k] = diff[k][D_W-1] ? D_W'(-diff[k]) : D_W'(diff[k]);
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                for (int k = 0; k < 4; k++)
                    sq_next[k] = ad_reg[k] * ad_reg[k];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                s_next = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) +
                         S_W'(sq_reg[2]) + S_W'(sq_reg[3]);
                rem_next   = '0;
                quo_next   = SIM_NUM_SQ;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (s_reg == '0)
                begin
                    sim_next   = SIM_EXACT;
                    state_next = ST_MUL;
                end
                else
                begin
                    if (!div_try[S_W])
                        rem_next = div_try[S_W-1:0];
                    else
                        rem_next = {rem_reg[S_W-2:0], quo_reg[NUM_W-1]};
                    quo_next  = {quo_reg[NUM_W-2:0], ~div_try[S_W]};
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'(NUM_W - 1))
                    begin
                        x_next     = {1'b0, quo_reg[NUM_W-2:0], ~div_try[S_W]};
                        res_next   = '0;
                        bit_next   = R_W'(1) << (NUM_W - 1);
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                // integer square root, one result bit per cycle
                if (x_reg >= sq_try)
                begin
                    x_next   = x_reg - sq_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    sim_next   = (x_reg >= sq_try) ? SIM_W'((res_reg >> 1) + bit_reg)
                                                   : SIM_W'(res_reg >> 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = sim_reg * err_rd;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                total_next = total_reg + TOT_W'(sim_reg);
                acc_next   = acc_reg + ACC_W'(prod_reg);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = (idx_reg + CNT_W'(1) == n_reg) ? ST_FIN : ST_RD;
            end
            ST_FIN:
            begin
                if (total_reg == '0)
                begin
                    est_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // quotient fits 24 bits, so the upper part is already below the divisor
                    frem_next  = TOT_W'(acc_reg >> ERR_W);
                    fq_next    = acc_reg[ERR_W-1:0];
                    step_next  = '0;
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                if (!fdiv_try[TOT_W])
                    frem_next = fdiv_try[TOT_W-1:0];
                else
                    frem_next = {frem_reg[TOT_W-2:0], fq_reg[ERR_W-1]};
                fq_next   = {fq_reg[ERR_W-2:0], ~fdiv_try[TOT_W]};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(ERR_W - 1))
                begin
                    est_next   = {fq_reg[ERR_W-2:0], ~fdiv_try[TOT_W]};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        cand_reg  <= cand_next;
        ad_reg    <= ad_next;
        sq_reg    <= sq_next;
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        x_reg     <= x_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        sim_reg   <= sim_next;
        prod_reg  <= prod_next;
        total_reg <= total_next;
        acc_reg   <= acc_next;
        frem_reg  <= frem_next;
        fq_reg    <= fq_next;
        step_reg  <= step_next;
        est_reg   <= est_next;
    end

    assign done     = done_reg;
    assign estimate = est_reg;
    assign idle     = (state_reg == ST_IDLE);

endmodule

@@ hw/rtl/inverse_distance_fitness_predictor_core.sv @@
// Top level of the inverse-distance fitness predictor.
// Depends on idfp_pkg, idfp_front and idfp_back.
//
//  channel   ports                                              accepted when
//  command   start, busy, mode, slot, param_*, member_error      start && !busy
//  result    done, estimate                                      done (one cycle)
//  config    cfg_we, cfg_wdata                                   cfg_we
//
// A load is written into the member stores as it leaves the queue; the back end stays idle.
// Per member a query reads the member and computes its distance, runs a 59-step
// restoring divide and a 30-step square root, and weights and sums the result (at
// zero distance the divide and root are skipped); a 24-step final divide follows.
// A two-entry queue decouples the command port; busy is high while it is full.
// The result strobe cannot be stalled. Reset clears the queue and sequencer;
// the member stores hold no reset value and must be loaded before use.
module inverse_distance_fitness_predictor_core
    import idfp_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [SLOT_W-1:0]    slot,
    input  logic signed [PRM_W-1:0] param_a11,
    input  logic signed [PRM_W-1:0] param_a22,
    input  logic signed [PRM_W-1:0] param_b1,
    input  logic signed [PRM_W-1:0] param_b2,
    input  logic [ERR_W-1:0]     member_error,
    output logic                 done,
    output logic [ERR_W-1:0]     estimate,
    input  logic                 cfg_we,
    input  logic [CNT_CFG_W-1:0] cfg_wdata
);

    logic [CNT_CFG_W-1:0] count_reg;
    item_t                item_in;
    item_t                item_q;
    queue_stat_t          stat;
    logic                 pop;
    logic                 back_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CNT_CFG_W'(64);
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    assign item_in.mode = mode;
    assign item_in.slot = slot;
    assign item_in.prm  = {param_b2, param_b1, param_a22, param_a11};
    assign item_in.err  = member_error;
    assign busy         = stat.full;

    idfp_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start && !busy),
        .item_in  (item_in),
        .pop      (pop),
        .item_out (item_q),
        .stat     (stat)
    );

    idfp_back #(.MAX_MEMBERS(MAX_MEMBERS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_q),
        .stat         (stat),
        .member_count (count_reg),
        .pop          (pop),
        .done         (done),
        .estimate     (estimate),
        .idle         (back_idle)
    );

    // every result returns the back end to idle, and no result comes straight from idle
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes back to back");

    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("queue filled without a command beat");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> back_idle && stat.valid)
        else $error("queue popped while back end working");

endmodule
